// ===== rtl/lcc_pkg.sv =====
// Shared types, constants and helpers for the LRU container tag cache.
`default_nettype none

package lcc_pkg;

  // Number of entries in the cache, one cell per recency position.
  localparam int ENTRIES    = 8;
  localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TAG_W      = 64;
  localparam int OUT_SLOT_W = 3;

  // Contents of one recency position: the physical slot found there,
  // its valid bit and its tag.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } cell_state_t;

  // Per-cycle commands from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic move_en;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_MOVE = 3'b100
  } state_t;

  // The reported slot is the low three bits of the physical slot number.
  function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+OUT_SLOT_W-1:0] ext;
    ext = {{OUT_SLOT_W{1'b0}}, s};
    return ext[OUT_SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcc_cell.sv =====
// One recency position of the cache: tag compare and move-to-front shift.
`default_nettype none

module lcc_cell
  import lcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SLOT_W-1:0] init_slot,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [TAG_W-1:0]  key,
  input  wire cell_state_t       prev,
  input  wire logic              sel_in,
  output cell_state_t            cur,
  output logic                   match_q,
  output logic                   sel_out
);

  // This position shifts when the moved entry sits here or further back.
  assign sel_out = match_q | sel_in;

  // Compare result is held until the move cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match_q <= cur.valid && (cur.tag == key);
    end
  end

  // Valid bit, slot number and tag take the neighbor's values on a shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      cur.slot  <= init_slot;
      cur.tag   <= '0;
    end else if (ctrl.move_en && sel_out) begin
      cur.valid <= prev.valid;
      cur.slot  <= prev.slot;
      cur.tag   <= prev.tag;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_container_cache_lookup.sv =====
// Top level of the LRU container tag cache: sequencer, cell chain and result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall  | key_tag[63:0]
//   out     | output    | out_valid/out_stall| hit, slot[2:0], evicted_valid, evicted_tag
//
// A lookup goes through the capture of the key, the parallel tag compare in
// every cell, and the move, in which the cells from the front back to the used
// entry shift one position toward the back and the front cell takes that entry.
// The move waits while an earlier result is still stalled in the output register.
// Reset clears all valid bits and puts slot i at position i.
// in_stall is high except while the sequencer is idle.
`default_nettype none

module lru_container_cache_lookup
  import lcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TAG_W-1:0]      key_tag,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       hit,
  output logic [OUT_SLOT_W-1:0]      slot,
  output logic                       evicted_valid,
  output logic [TAG_W-1:0]           evicted_tag
);

  state_t             state, state_next;
  logic [TAG_W-1:0]   key_q;
  logic               in_fire, move_go;
  cell_ctrl_t         ctrl;
  cell_state_t        cells [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] sel_vec;
  logic               any_hit;
  logic [SLOT_W-1:0]  hit_slot;
  cell_state_t        front;
  cell_state_t        last;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign move_go  = (state == ST_MOVE) && (!out_valid || !out_stall);

  assign ctrl.cmp_en  = (state == ST_CMP);
  assign ctrl.move_en = move_go;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_CMP;
      ST_CMP:  state_next = ST_MOVE;
      ST_MOVE: if (move_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Key register for the transaction in flight.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_q <= key_tag;
    end
  end

  // Hit detection and the slot of the matching entry (at most one matches).
  assign any_hit = |match_vec;
  assign last    = cells[ENTRIES-1];

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) hit_slot = hit_slot | cells[i].slot;
    end
  end

  // The entry that lands at the front: the hit entry, or the oldest one refilled.
  always_comb begin
    front.valid = 1'b1;
    front.slot  = any_hit ? hit_slot : last.slot;
    front.tag   = key_q;
  end

  // Chain of cells, position 0 at the front.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cell_state_t prev_g;
    logic        sel_in_g;

    if (g == 0) begin : g_head
      assign prev_g = front;
    end else begin : g_body
      assign prev_g = cells[g-1];
    end

    if (g == ENTRIES - 1) begin : g_tail
      assign sel_in_g = !any_hit;
    end else begin : g_mid
      assign sel_in_g = sel_vec[g+1];
    end

    lcc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .init_slot (SLOT_W'(g)),
      .ctrl      (ctrl),
      .key       (key_q),
      .prev      (prev_g),
      .sel_in    (sel_in_g),
      .cur       (cells[g]),
      .match_q   (match_vec[g]),
      .sel_out   (sel_vec[g])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_go) begin
      hit           <= any_hit;
      slot          <= to_out_slot(front.slot);
      evicted_valid <= !any_hit && last.valid;
      evicted_tag   <= (!any_hit && last.valid) ? last.tag : '0;
    end
  end

  // A tag is stored at most once, so at most one cell matches.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |-> $onehot0(match_vec))
    else $error("more than one cell matched the key");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted_valid)
    else $error("eviction reported on a hit");

  // After a move the front cell holds a valid entry with the looked-up key.
  a_front_valid: assert property (@(posedge clk) disable iff (rst)
    move_go |=> (cells[0].valid && (cells[0].tag == $past(key_q))))
    else $error("front cell does not hold the looked-up key");

  // A result register is loaded only by a move.
  a_out_from_move: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MOVE))
    else $error("result appeared without a move cycle");

endmodule

`default_nettype wire

// ===== bench/cache_lookup_checker.sv =====
// Checker for the LRU container tag cache: predicts every lookup and compares results.
`timescale 1ns / 1ps

module cache_lookup_checker
  import lcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [TAG_W-1:0]      key_tag,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic                  hit,
  input  wire logic [OUT_SLOT_W-1:0] slot,
  input  wire logic                  evicted_valid,
  input  wire logic [TAG_W-1:0]      evicted_tag,
  output int                         errors,
  output int                         pending,
  output int                         lookups,
  output int                         hit_count,
  output int                         evict_count
);

  // One lookup result as the block reports it.
  typedef struct packed {
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  evicted_valid;
    logic [TAG_W-1:0]      evicted_tag;
  } lookup_result_t;

  // Shadow copy of the cache contents and of the recency list.
  logic [TAG_W-1:0]  line_tag   [ENTRIES];
  logic              line_valid [ENTRIES];
  logic [SLOT_W-1:0] rank       [ENTRIES];

  lookup_result_t expected_lookups[$];

  initial begin
    errors      = 0;
    pending     = 0;
    lookups     = 0;
    hit_count   = 0;
    evict_count = 0;
  end

  // Looks up one tag, moves the used entry to the front and returns the result.
  function automatic lookup_result_t predict_lookup(input logic [TAG_W-1:0] key);
    lookup_result_t r;
    int found;
    logic [SLOT_W-1:0] s;
    found = -1;
    r = '0;
    for (int pos = 0; pos < ENTRIES; pos++) begin
      if (found < 0 && line_valid[rank[pos]] && line_tag[rank[pos]] == key) begin
        found = pos;
      end
    end
    if (found >= 0) begin
      s = rank[found];
      r.hit = 1'b1;
    end else begin
      // A miss reuses the least recently used entry, valid or not.
      found = ENTRIES - 1;
      s = rank[found];
      r.evicted_valid = line_valid[s];
      r.evicted_tag   = line_valid[s] ? line_tag[s] : '0;
      line_tag[s]     = key;
      line_valid[s]   = 1'b1;
    end
    r.slot = OUT_SLOT_W'(s);
    for (int i = found; i > 0; i--) begin
      rank[i] = rank[i-1];
    end
    rank[0] = s;
    return r;
  endfunction

  // Prints one mismatch line and counts every mismatch.
  task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
                                 input logic [TAG_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors = errors + 1;
  endtask

  // Compare first, then predict, so a result never meets the lookup of the same edge.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        rank[i]       = SLOT_W'(i);
      end
      expected_lookups.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected result transaction", evicted_tag, '0);
        end else begin
          want = expected_lookups.pop_front();
          if (hit !== want.hit)
            report_mismatch("hit", TAG_W'(hit), TAG_W'(want.hit));
          if (slot !== want.slot)
            report_mismatch("slot", TAG_W'(slot), TAG_W'(want.slot));
          if (evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", TAG_W'(evicted_valid), TAG_W'(want.evicted_valid));
          if (evicted_tag !== want.evicted_tag)
            report_mismatch("evicted_tag", evicted_tag, want.evicted_tag);
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_lookup(key_tag);
        expected_lookups.push_back(want);
        lookups     <= lookups + 1;
        hit_count   <= hit_count + int'(want.hit);
        evict_count <= evict_count + int'(want.evicted_valid);
      end
      pending <= expected_lookups.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the testbench: clock, reset, lookup stimulus, result consumer and verdict.
`timescale 1ns / 1ps

module testbench;
  import lcc_pkg::*;

  localparam int RANDOM_LOOKUPS = 1530;
  localparam int HOLD_CYCLES    = 500;
  localparam int IDLE_LIMIT     = 4000;
  localparam int POOL_SIZE      = 12;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  out_stall = 1'b0;
  logic [TAG_W-1:0]      key_tag   = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  hit;
  logic [OUT_SLOT_W-1:0] slot;
  logic                  evicted_valid;
  logic [TAG_W-1:0]      evicted_tag;

  int errors, pending, lookups, hit_count, evict_count;
  int idle_cycles = 0;
  int sent = 0;
  logic [TAG_W-1:0] tag_pool [POOL_SIZE];

  lru_container_cache_lookup dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .key_tag(key_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .slot(slot), .evicted_valid(evicted_valid), .evicted_tag(evicted_tag)
  );

  cache_lookup_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .key_tag(key_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .slot(slot), .evicted_valid(evicted_valid), .evicted_tag(evicted_tag),
    .errors(errors), .pending(pending), .lookups(lookups),
    .hit_count(hit_count), .evict_count(evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one lookup after a random gap and waits until it is taken.
  task automatic send_lookup(input logic [TAG_W-1:0] t);
    int gap;
    gap = ((sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_tag  <= t;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [TAG_W-1:0] random_tag();
    return {$urandom(), $urandom()};
  endfunction

  // Stimulus: directed corner cases, then mostly reuse of a small tag pool.
  initial begin
    logic [TAG_W-1:0] t;
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero tag into invalid entries, fill all eight, hits at the back, evictions.
    send_lookup(64'h0);
    send_lookup(64'h0);
    send_lookup(64'hFFFF_FFFF_FFFF_FFFF);
    send_lookup(64'hAAAA_AAAA_AAAA_AAAA);
    send_lookup(64'h5555_5555_5555_5555);
    send_lookup(64'h1);
    send_lookup(64'h2);
    send_lookup(64'h3);
    send_lookup(64'h4);
    send_lookup(64'h0);
    send_lookup(64'hFFFF_FFFF_FFFF_FFFF);
    send_lookup(64'h8000_0000_0000_0000);
    send_lookup(64'hAAAA_AAAA_AAAA_AAAA);
    send_lookup(64'hAAAA_AAAA_AAAA_AAAA);
    send_lookup(64'h0000_0001_0000_0000);
    send_lookup(64'h5555_5555_5555_5555);
    send_lookup(64'h4);
    send_lookup(64'h1);
    send_lookup(64'hFFFF_FFFF_FFFF_FFFE);
    send_lookup(64'h7FFF_FFFF_FFFF_FFFF);

    for (int i = 0; i < POOL_SIZE; i++) begin
      tag_pool[i] = random_tag();
    end

    // Pool reuse gives hits at every depth; fresh and near-miss tags force evictions.
    for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        t = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 80) begin
        t = tag_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (64'h1 << $urandom_range(0, 63));
      end else if (pick < 95) begin
        t = random_tag();
      end else begin
        t = tag_pool[0];
        tag_pool[$urandom_range(0, POOL_SIZE - 1)] = random_tag();
      end
      send_lookup(t);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (8) @(posedge clk);
    $display("Summary: %0d lookups, %0d hits, %0d misses, %0d evictions of valid tags.",
             lookups, hit_count, lookups - hit_count, evict_count);
    $display("Summary: random stalls on both sides and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result consumer: random stalls, quiet stretches, and one long hold-off.
  initial begin
    int n;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken == 300) begin
        n = HOLD_CYCLES;
      end else if ((taken / 64) % 4 == 3) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 17);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a transaction.", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
